// File: rtl/ppru_pkg.sv
// Shared types, codes and defaults for the palette pixel row unpacker.
package ppru_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam int COLOUR_W = 24;
    localparam int CFG_W    = 13;

    // Command codes
    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    // Register indexes
    localparam logic REG_DEPTH_SELECT = 1'b0;
    localparam logic REG_ROW_WIDTH    = 1'b1;

    // Depth select codes
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;
    localparam logic [1:0] DEPTH_8BPP = 2'd2;

    localparam logic [1:0]  RST_DEPTH_SELECT = DEPTH_8BPP;
    localparam logic [12:0] RST_ROW_WIDTH    = 13'd28;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] entry_blue;
        logic [7:0] entry_green;
        logic [7:0] entry_red;
    } src_word_t;

    typedef struct packed {
        logic [7:0]  pixel_blue;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_red;
        logic [11:0] column;
        logic        row_end;
        logic        last;
    } pix_word_t;

    typedef struct packed {
        logic [11:0] column;
        logic        row_end;
        logic        last;
    } pix_meta_t;

endpackage

// File: rtl/ppru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ppru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/palette_pixel_row_unpacker_top.sv
// Top level of the palette pixel row unpacker: sequencer, colour table and output queue.
// A byte passes the issue slot, the colour RAM read register and the output queue before
// its first pixel is offered. Throughput: one pixel per cycle while the queue has room;
// a data byte takes one slot access per pixel (8, 2 or 1, fewer at a row end), a padding
// byte or a palette write one, as the single issue slot in front of the colour table RAM
// allows one read or one write a cycle. Reset clears the row state and every entry valid
// bit and resets the registers; an unwritten entry reads as zero with no clearing pass.
module palette_pixel_row_unpacker_top
    import ppru_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    // Input words
    input  logic             src_valid,
    output logic             src_stall,
    input  src_word_t        src_word,
    // Pixel words
    output logic             pix_valid,
    input  logic             pix_stall,
    output pix_word_t        pix_word,
    // Configuration writes
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int Q_DEPTH  = 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  depth_reg;
    logic [12:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= RST_DEPTH_SELECT;
            width_reg <= RST_ROW_WIDTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEPTH_SELECT: depth_reg <= cfg_data[1:0];
                REG_ROW_WIDTH:    width_reg <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    // Effective row width: zero means one, clamp to the supported maximum.
    logic [12:0] eff_width;

    always_comb
    begin
        if (width_reg == 13'd0)
        begin
            eff_width = 13'd1;
        end
        else if ({4'd0, width_reg} > 17'(MAX_WIDTH))
        begin
            eff_width = 13'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    // ------------------------------------------------------------------
    // Current word held in the issue slot
    // ------------------------------------------------------------------
    logic        cur_valid_reg, cur_valid_next;
    src_word_t   cur_word_reg;
    logic [7:0]  shift_reg, shift_next;   // pixel bits still to emit, MSB first
    logic [2:0]  pix_cnt_reg, pix_cnt_next;

    // Row state
    logic [12:0] col_reg, col_next;
    logic [1:0]  phase_reg, phase_next;
    logic        pad_reg, pad_next;

    // Valid bit per table entry, cleared at reset
    logic [PALETTE_DEPTH-1:0] entry_ok_reg, entry_ok_next;

    // Read in flight
    logic        rd_valid_reg, rd_valid_next;
    logic        rd_hit_reg, rd_hit_next;
    pix_meta_t   rd_meta_reg, rd_meta_next;

    // Output queue
    pix_word_t   q_mem [Q_DEPTH];
    logic [1:0]  q_wptr_reg, q_rptr_reg, q_cnt_reg;
    logic        q_push, q_pop;

    // RAM interface
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [COLOUR_W-1:0] ram_rdata;

    logic        accept, finish, credit;
    logic [7:0]  pix_index;
    logic        idx_in_range, wr_in_range;
    logic [2:0]  per_byte_m1;
    logic [3:0]  shift_amt;
    logic [12:0] col_eff, col_inc;
    logic        row_done, last_pix;

    // Room in the queue for the pixel issued now, counting the one still in flight.
    assign credit = ({1'b0, q_cnt_reg} + {2'd0, rd_valid_reg}) < 3'(Q_DEPTH);

    // Take the pixel index from the top bits of the shift register.
    always_comb
    begin
        case (depth_reg)
            DEPTH_1BPP:
            begin
                pix_index   = {7'd0, shift_reg[7]};
                per_byte_m1 = 3'd7;
                shift_amt   = 4'd1;
            end
            DEPTH_4BPP:
            begin
                pix_index   = {4'd0, shift_reg[7:4]};
                per_byte_m1 = 3'd1;
                shift_amt   = 4'd4;
            end
            default:
            begin
                pix_index   = shift_reg;
                per_byte_m1 = 3'd0;
                shift_amt   = 4'd8;
            end
        endcase
    end

    assign idx_in_range = {1'b0, pix_index} < 9'(PALETTE_DEPTH);
    assign wr_in_range  = {1'b0, cur_word_reg.palette_index} < 9'(PALETTE_DEPTH);
    assign ram_waddr    = cur_word_reg.palette_index[AW-1:0];
    assign ram_raddr    = pix_index[AW-1:0];

    // Start a new row when the column stands beyond a narrowed width.
    assign col_eff  = (col_reg >= eff_width) ? 13'd0 : col_reg;
    assign col_inc  = col_eff + 13'd1;
    assign row_done = col_inc >= eff_width;
    assign last_pix = row_done || (pix_cnt_reg == per_byte_m1);

    // Issue: one table access a cycle, in input order, so a palette write can
    // never overtake or be overtaken by a pixel lookup.
    always_comb
    begin
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        finish        = 1'b0;
        shift_next    = shift_reg;
        pix_cnt_next  = pix_cnt_reg;
        col_next      = col_reg;
        phase_next    = phase_reg;
        pad_next      = pad_reg;
        entry_ok_next = entry_ok_reg;
        rd_valid_next = 1'b0;
        rd_hit_next   = rd_hit_reg;
        rd_meta_next  = rd_meta_reg;

        if (cur_valid_reg)
        begin
            if (cur_word_reg.command == CMD_PALETTE)
            begin
                // Drop writes beyond the table.
                ram_we = wr_in_range;
                if (wr_in_range)
                begin
                    entry_ok_next[ram_waddr] = 1'b1;
                end
                finish = 1'b1;
            end
            else if (pad_reg)
            begin
                // Consume a padding byte.
                phase_next = phase_reg + 2'd1;
                if (phase_next == 2'd0)
                begin
                    pad_next = 1'b0;
                end
                finish = 1'b1;
            end
            else if (credit)
            begin
                ram_re               = 1'b1;
                rd_valid_next        = 1'b1;
                rd_hit_next          = idx_in_range && entry_ok_reg[ram_raddr];
                rd_meta_next.column  = col_eff[11:0];
                rd_meta_next.row_end = row_done;
                rd_meta_next.last    = last_pix;
                col_next             = row_done ? 13'd0 : col_inc;
                shift_next           = shift_reg << shift_amt;
                pix_cnt_next         = pix_cnt_reg + 3'd1;
                if (last_pix)
                begin
                    finish     = 1'b1;
                    phase_next = phase_reg + 2'd1;
                    if (row_done && (phase_next != 2'd0))
                    begin
                        pad_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold the input while the slot is busy; take the next word as the slot frees.
    assign src_stall      = cur_valid_reg && !finish;
    assign accept         = src_valid && !src_stall;
    assign cur_valid_next = accept ? 1'b1 : (finish ? 1'b0 : cur_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pix_cnt_reg   <= 3'd0;
            col_reg       <= 13'd0;
            phase_reg     <= 2'd0;
            pad_reg       <= 1'b0;
            entry_ok_reg  <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pix_cnt_reg   <= accept ? 3'd0 : pix_cnt_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            pad_reg       <= pad_next;
            entry_ok_reg  <= entry_ok_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_word_reg <= src_word;
        end
        shift_reg   <= accept ? src_word.data_byte : shift_next;
        rd_hit_reg  <= rd_hit_next;
        rd_meta_reg <= rd_meta_next;
    end

    ppru_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_colour_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data ({cur_word_reg.entry_red, cur_word_reg.entry_green, cur_word_reg.entry_blue}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Output queue: lookup result is pushed here in the cycle after issue.
    // ------------------------------------------------------------------
    pix_word_t push_word;

    always_comb
    begin
        push_word.pixel_blue  = rd_hit_reg ? ram_rdata[7:0]   : 8'd0;
        push_word.pixel_green = rd_hit_reg ? ram_rdata[15:8]  : 8'd0;
        push_word.pixel_red   = rd_hit_reg ? ram_rdata[23:16] : 8'd0;
        push_word.column      = rd_meta_reg.column;
        push_word.row_end     = rd_meta_reg.row_end;
        push_word.last        = rd_meta_reg.last;
    end

    assign q_push    = rd_valid_reg;
    assign pix_valid = q_cnt_reg != 2'd0;
    assign q_pop     = pix_valid && !pix_stall;
    assign pix_word  = q_mem[q_rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wptr_reg <= 2'd0;
            q_rptr_reg <= 2'd0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (q_push)
            begin
                q_wptr_reg <= (q_wptr_reg == 2'(Q_DEPTH - 1)) ? 2'd0 : q_wptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                q_rptr_reg <= (q_rptr_reg == 2'(Q_DEPTH - 1)) ? 2'd0 : q_rptr_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wptr_reg] <= push_word;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A lookup in flight always finds room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (q_cnt_reg != 2'(Q_DEPTH)))
        else $error("pixel pushed into a full output queue");

    // Padding is only pending inside a four-byte group.
    assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> (phase_reg != 2'd0))
        else $error("padding pending at a group boundary");

    // The pixel that ends a row is the final pixel of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && rd_meta_reg.row_end) |-> rd_meta_reg.last)
        else $error("row end without last flag");

    // A palette write completes in the cycle it reaches the slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && (cur_word_reg.command == CMD_PALETTE)) |-> !src_stall)
        else $error("palette write held in the issue slot");

endmodule
